>>> rtl/core/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants for the stereo RMS meter
// Sample format, field widths, the dB scaling coefficient and the sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int MAX_WINDOW_DEFAULT = 1024;
   localparam int WIN_W              = 11;
   localparam int RESET_WINDOW       = 256;
   localparam int SQ_W               = 2 * SAMPLE_BITS - 1;
   localparam int LOG_FRAC_BITS      = 16;
   localparam int MANT_FRAC          = 30;
   localparam int DB_COEF_Q16        = 394566;  // 20*log10(2) in Q16
   localparam int FIELD_W            = 16;

   typedef struct packed {
      logic signed [FIELD_W-1:0] sample_left;
      logic signed [FIELD_W-1:0] sample_right;
   } req_type;

   typedef struct packed {
      logic        [FIELD_W-1:0] rms_left;
      logic        [FIELD_W-1:0] rms_right;
      logic signed [FIELD_W-1:0] db_left;
      logic signed [FIELD_W-1:0] db_right;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_DB_NORM,
      ST_DB_LOG,
      ST_DB_SCALE,
      ST_DB_ROUND,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/stereo_sliding_rms_meter.sv
// ----------------------------------------------------------------------------
// stereo_sliding_rms_meter: sliding-window RMS / instantaneous dB meter
// One stereo Q1.15 sample pair per request; one level result per request.
// ----------------------------------------------------------------------------
// Usage
//   req channel (valid/ready) carries a left/right sample pair. rsp channel
//   (valid/ready) returns rms_left/right (Q1.15 magnitude) and db_left/right
//   (Q7.8 dBFS). csr_write_enable/csr_write_data set window_length; a value
//   of 0 selects dB mode, values above MAX_WINDOW are stored as MAX_WINDOW.
// Sequencing
//   RMS mode: the time from accept to rsp_valid is set by the bit-serial
//   divide over SUM_W bits (SUM_W = 41 at the default depth) and square
//   root that run once per channel; the next request waits for ST_IDLE.
//   dB mode: the time is set by the 16 squaring steps of the log unit;
//   a zero sample skips them. One 32x32 multiplier serves all products.
// Reset / window write
//   Both start a clearing pass over all MAX_WINDOW entries of the square
//   ring; req_ready stays low until it completes. Sums and ring position
//   clear at once.
// Stalls
//   A finished result sits in the output register; the next request is
//   accepted meanwhile, and the sequencer waits only when it has a second
//   result and the first has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_sliding_rms_meter #(
   parameter int MAX_WINDOW = srm_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire srm_pkg::req_type           req,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output srm_pkg::rsp_type                rsp,
   input  wire logic                       csr_write_enable,
   input  wire logic [srm_pkg::WIN_W-1:0]  csr_write_data
);
   import srm_pkg::*;

   localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam int EW    = $clog2(SAMPLE_BITS);
   localparam int NEG_W = EW + LOG_FRAC_BITS;
   localparam int RST_WIN = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

   // sequencer
   state_type state_ff, state_in;

   // configuration and window state
   logic [WIN_W-1:0]    window_ff;
   logic [WIN_W-1:0]    window_wr;
   logic [PW-1:0]       pos_ff;
   logic [PW-1:0]       pos_use;
   logic [PW:0]         pos_inc;
   logic [PW-1:0]       pos_wrap;
   logic [PW-1:0]       clr_ff;
   logic                clr_last;
   logic [SUM_W-1:0]    sum_l_ff, sum_r_ff;
   logic [SUM_W-1:0]    sum_l_new, sum_r_new;

   // square ring: {right, left} per entry
   logic [2*SQ_W-1:0]   ring_mem [MAX_WINDOW];
   logic [2*SQ_W-1:0]   rd_ff;

   // per-request operands
   logic [SAMPLE_BITS-1:0] mag_l_ff, mag_r_ff, mag_sel;
   logic                   ch_ff;
   logic [SQ_W-1:0]        sq_l_ff, sq_r_ff;

   // shared multiplier
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_p;

   // divider / square root
   logic [CNT_W-1:0]    cnt_ff;
   logic [SUM_W-1:0]    dq_ff;
   logic [WIN_W:0]      rem_ff;
   logic [WIN_W:0]      div_t;
   logic                div_ge;
   logic [SQ_W-1:0]     v_ff;
   logic [SQ_W:0]       res_ff;
   logic [SQ_W-1:0]     bit_ff;
   logic [SQ_W:0]       sq_t;
   logic                sq_ge;

   // log unit
   logic [31:0]         m_ff;
   logic [31:0]         m2;
   logic [LOG_FRAC_BITS-1:0] frac_ff;
   logic [EW-1:0]       e_ff, e_comb;
   logic [NEG_W-1:0]    neg;
   logic [63:0]         prod_ff;
   logic [63:0]         q_round;
   logic [FIELD_W-1:0]  q_sat;
   logic [FIELD_W-1:0]  db_val;

   // results and output register
   logic [FIELD_W-1:0]  rms_l_ff, rms_r_ff, db_l_ff, db_r_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                out_load;
   logic                accept;

   // ------------------------------------------------------------------------
   // combinational datapath
   // ------------------------------------------------------------------------
   assign accept    = req_valid && req_ready;
   assign mag_sel   = ch_ff ? mag_r_ff : mag_l_ff;
   assign window_wr = (32'(csr_write_data) > 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                              : csr_write_data;
   assign clr_last  = (32'(clr_ff) == 32'(MAX_WINDOW - 1));

   // ring position, taken as zero when out of the window
   assign pos_use  = (32'(pos_ff) >= 32'(window_ff)) ? '0 : pos_ff;
   assign pos_inc  = {1'b0, pos_use} + 1'b1;
   assign pos_wrap = (32'(pos_inc) >= 32'(window_ff)) ? '0 : pos_inc[PW-1:0];

   assign sum_l_new = SUM_W'({1'b0, sum_l_ff} + (SUM_W+1)'(sq_l_ff)
                             - (SUM_W+1)'(rd_ff[SQ_W-1:0]));
   assign sum_r_new = SUM_W'({1'b0, sum_r_ff} + (SUM_W+1)'(sq_r_ff)
                             - (SUM_W+1)'(rd_ff[2*SQ_W-1:SQ_W]));

   // restoring divide step
   assign div_t  = {rem_ff[WIN_W-1:0], dq_ff[SUM_W-1]};
   assign div_ge = (div_t >= {1'b0, window_ff});

   // square root step
   assign sq_t  = res_ff + {1'b0, bit_ff};
   assign sq_ge = ({1'b0, v_ff} >= sq_t);

   // leading one of the magnitude
   always_comb begin
      e_comb = '0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (mag_sel[i]) begin
            e_comb = EW'(i);
         end
      end
   end

   assign m2  = mul_p[MANT_FRAC+31:MANT_FRAC];
   assign neg = (NEG_W'(SAMPLE_BITS - 1) - NEG_W'(e_ff)) * NEG_W'(2 ** LOG_FRAC_BITS)
                - NEG_W'(frac_ff);

   assign q_round = prod_ff + 64'(2 ** 23);
   assign q_sat   = (q_round[63:24] > 40'h8000) ? 16'h8000 : q_round[39:24];
   assign db_val  = ~q_sat + 1'b1;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_SQUARE: begin
            mul_a = 32'(mag_sel);
            mul_b = 32'(mag_sel);
         end
         ST_DB_LOG: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_DB_SCALE: begin
            mul_a = 32'(neg);
            mul_b = 32'(DB_COEF_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = (window_ff == '0) ? ST_DB_NORM : ST_READ;
            end
         end
         ST_READ:      state_in = ST_SQUARE;
         ST_SQUARE: begin
            if (ch_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:    state_in = ST_DIV_INIT;
         ST_DIV_INIT:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = ST_SQRT_INIT;
            end
         end
         ST_SQRT_INIT: state_in = ST_SQRT;
         ST_SQRT: begin
            if (bit_ff == '0) begin
               state_in = ch_ff ? ST_OUT : ST_DIV_INIT;
            end
         end
         ST_DB_NORM: begin
            if (mag_sel == '0) begin
               state_in = ch_ff ? ST_OUT : ST_DB_NORM;
            end else begin
               state_in = ST_DB_LOG;
            end
         end
         ST_DB_LOG: begin
            if (cnt_ff == CNT_W'(LOG_FRAC_BITS - 1)) begin
               state_in = ST_DB_SCALE;
            end
         end
         ST_DB_SCALE:  state_in = ST_DB_ROUND;
         ST_DB_ROUND:  state_in = ch_ff ? ST_OUT : ST_DB_NORM;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_CLEAR;
      endcase
      // window write restarts the clearing pass
      if (csr_write_enable) begin
         state_in = ST_CLEAR;
      end
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WIN_W'(RST_WIN);
         pos_ff       <= '0;
         sum_l_ff     <= '0;
         sum_r_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= window_wr;
            pos_ff    <= '0;
            sum_l_ff  <= '0;
            sum_r_ff  <= '0;
            clr_ff    <= '0;
         end else begin
            if (state_ff == ST_CLEAR) begin
               clr_ff <= clr_last ? '0 : clr_ff + 1'b1;
            end
            if (state_ff == ST_UPDATE) begin
               sum_l_ff <= sum_l_new;
               sum_r_ff <= sum_r_new;
               pos_ff   <= pos_wrap;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // square ring memory
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         ring_mem[clr_ff] <= '0;
      end else if (state_ff == ST_UPDATE) begin
         ring_mem[pos_use] <= {sq_r_ff, sq_l_ff};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= ring_mem[pos_use];
      end
   end

   // ------------------------------------------------------------------------
   // arithmetic datapath
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= 1'b0;
      end else if (accept) begin
         ch_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_SQUARE:   ch_ff <= ~ch_ff;
            ST_SQRT: begin
               if (bit_ff == '0) begin
                  ch_ff <= 1'b1;
               end
            end
            ST_DB_NORM: begin
               if (mag_sel == '0) begin
                  ch_ff <= ~ch_ff;
               end
            end
            ST_DB_ROUND: ch_ff <= ~ch_ff;
            default:     ch_ff <= ch_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_l_ff <= req.sample_left[SAMPLE_BITS-1] ? (~req.sample_left + 1'b1)
                                                    : req.sample_left;
         mag_r_ff <= req.sample_right[SAMPLE_BITS-1] ? (~req.sample_right + 1'b1)
                                                     : req.sample_right;
         rms_l_ff <= '0;
         rms_r_ff <= '0;
         db_l_ff  <= '0;
         db_r_ff  <= '0;
      end
      case (state_ff)
         ST_SQUARE: begin
            if (ch_ff) begin
               sq_r_ff <= mul_p[SQ_W-1:0];
            end else begin
               sq_l_ff <= mul_p[SQ_W-1:0];
            end
         end
         ST_DIV_INIT: begin
            dq_ff  <= ch_ff ? sum_r_ff : sum_l_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= div_ge ? (div_t - {1'b0, window_ff}) : div_t;
            dq_ff  <= {dq_ff[SUM_W-2:0], div_ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_SQRT_INIT: begin
            v_ff   <= dq_ff[SQ_W-1:0];
            res_ff <= '0;
            bit_ff <= {1'b1, {(SQ_W-1){1'b0}}};
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               if (ch_ff) begin
                  rms_r_ff <= res_ff[FIELD_W-1:0];
               end else begin
                  rms_l_ff <= res_ff[FIELD_W-1:0];
               end
            end else begin
               if (sq_ge) begin
                  v_ff   <= v_ff - sq_t[SQ_W-1:0];
                  res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         ST_DB_NORM: begin
            if (mag_sel == '0) begin
               if (ch_ff) begin
                  db_r_ff <= 16'h8000;
               end else begin
                  db_l_ff <= 16'h8000;
               end
            end
            e_ff    <= e_comb;
            m_ff    <= 32'(mag_sel) << (5'(MANT_FRAC) - 5'(e_comb));
            frac_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_DB_LOG: begin
            m_ff    <= m2[31] ? (m2 >> 1) : m2;
            frac_ff <= {frac_ff[LOG_FRAC_BITS-2:0], m2[31]};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         ST_DB_SCALE: begin
            prod_ff <= mul_p;
         end
         ST_DB_ROUND: begin
            if (ch_ff) begin
               db_r_ff <= db_val;
            end else begin
               db_l_ff <= db_val;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_ff.rms_left  <= rms_l_ff;
         rsp_ff.rms_right <= rms_r_ff;
         rsp_ff.db_left   <= db_l_ff;
         rsp_ff.db_right  <= db_r_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/srm_checker.sv
// ----------------------------------------------------------------------------
// srm_checker: port-level checks for the stereo RMS meter
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire srm_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire srm_pkg::rsp_type rsp
);
   import srm_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response dropped or changed while stalled");

   // one request in flight: not ready right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // RMS and dB fields are never both populated
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.rms_left == '0 && rsp.rms_right == '0) ||
                    (rsp.db_left == '0 && rsp.db_right == '0))
      else $error("RMS and dB fields both nonzero");

   // dB output never positive
   a_db_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.db_left <= 0) && (rsp.db_right <= 0))
      else $error("positive dB level");

endmodule

bind stereo_sliding_rms_meter srm_checker u_srm_checker (.*);

`default_nettype wire

>>> tb/srm_level_checker.sv
// ----------------------------------------------------------------------------
// srm_level_checker: predicts and checks the stereo RMS meter results
// Watches both channels, keeps its own ring, sums and window setting, and
// compares every result against the oldest predicted level.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_level_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire srm_pkg::req_type           req,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire srm_pkg::rsp_type           rsp,
   input  wire logic                       csr_write_enable,
   input  wire logic [srm_pkg::WIN_W-1:0]  csr_write_data,
   output int                              mismatch_count,
   output int                              pending_count
);
   import srm_pkg::*;

   localparam int MAXW = MAX_WINDOW_DEFAULT;

   logic [SQ_W-1:0] sq_l [MAXW];
   logic [SQ_W-1:0] sq_r [MAXW];
   logic [40:0]     acc_l, acc_r;
   int unsigned     ring_pos, win_len;
   rsp_type         level_queue [$];

   function automatic logic [15:0] mag_of(logic [15:0] s);
      return s[15] ? 16'(~s + 16'd1) : s;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] level_dbfs(logic [15:0] mag);
      int unsigned e;
      logic [63:0] m, frac, neg, q;
      e    = 0;
      frac = 0;
      if (mag == 0) return 16'h8000;
      while (e < 15 && (mag >> (e + 1)) != 0) e++;
      m = 64'(mag) << (30 - e);
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         m = (m * m) >> 30;
         frac <<= 1;
         if (m >= (64'd2 << 30)) begin
            m >>= 1;
            frac |= 1;
         end
      end
      neg = (64'(SAMPLE_BITS - 1 - e) << LOG_FRAC_BITS) - frac;
      q   = (neg * 64'(DB_COEF_Q16) + (64'd1 << 23)) >> 24;
      if (q > 64'h8000) q = 64'h8000;
      return 16'(~q + 1);
   endfunction

   task automatic clear_ring();
      for (int i = 0; i < MAXW; i++) begin
         sq_l[i] = 0;
         sq_r[i] = 0;
      end
      ring_pos = 0;
      acc_l    = 0;
      acc_r    = 0;
   endtask

   task automatic predict_level(req_type r);
      rsp_type     x;
      logic [15:0] ml, mr;
      logic [SQ_W-1:0] nl, nr;
      int unsigned p;
      ml = mag_of(r.sample_left);
      mr = mag_of(r.sample_right);
      x  = '0;
      if (win_len == 0) begin
         x.db_left  = level_dbfs(ml);
         x.db_right = level_dbfs(mr);
      end else begin
         p = (ring_pos >= win_len) ? 0 : ring_pos;
         nl = SQ_W'(ml) * SQ_W'(ml);
         nr = SQ_W'(mr) * SQ_W'(mr);
         acc_l = acc_l + nl - sq_l[p];
         acc_r = acc_r + nr - sq_r[p];
         sq_l[p] = nl;
         sq_r[p] = nr;
         p++;
         ring_pos = (p >= win_len) ? 0 : p;
         x.rms_left  = 16'(int_sqrt(64'(acc_l) / win_len));
         x.rms_right = 16'(int_sqrt(64'(acc_r) / win_len));
      end
      level_queue.push_back(x);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         win_len        = RESET_WINDOW;
         mismatch_count = 0;
         level_queue.delete();
         clear_ring();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (level_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %h", rsp);
            end else begin
               want = level_queue.pop_front();
               if (rsp !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: rms %0d/%0d db %0d/%0d exp rms %0d/%0d db %0d/%0d",
                              rsp.rms_left, rsp.rms_right, rsp.db_left, rsp.db_right,
                              want.rms_left, want.rms_right, want.db_left,
                              want.db_right);
               end
            end
         end
         if (req_valid && req_ready) predict_level(req);
         if (csr_write_enable) begin
            win_len = (csr_write_data > MAXW) ? MAXW : csr_write_data;
            clear_ring();
         end
      end
      pending_count = level_queue.size();
   end
endmodule

`default_nettype wire

>>> tb/tb_stereo_sliding_rms_meter.sv
// ----------------------------------------------------------------------------
// tb_stereo_sliding_rms_meter: stimulus and verdict for the RMS meter
// Directed extremes, then random sample streams over several window
// settings including dB mode, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stereo_sliding_rms_meter;
   import srm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp;
   logic csr_write_enable = 0;
   logic [WIN_W-1:0] csr_write_data = '0;
   int mismatch_count, pending_count;
   int cycle_count = 0;
   bit long_hold = 0;     // receiver holds off while set

   localparam int CYCLE_LIMIT = 1500000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   stereo_sliding_rms_meter dut (
      .clock, .reset, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready,
      .rsp, .csr_write_enable, .csr_write_data
   );

   srm_level_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready,
      .rsp, .csr_write_enable, .csr_write_data, .mismatch_count, .pending_count
   );

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: own stall pattern, with long hold-off windows on request.
   always @(posedge clock) begin
      if (long_hold) rsp_ready <= 0;
      else case (cycle_count[9:8])
         2'd0:    rsp_ready <= 1;                      // no stalls
         2'd1:    rsp_ready <= ($urandom_range(3) != 0);
         default: rsp_ready <= ($urandom_range(1) == 0);
      endcase
   end

   // One request, held until accepted; req_valid then drops.
   task automatic send_request(logic [15:0] l, logic [15:0] r);
      req_valid <= 1;
      req       <= '{sample_left: l, sample_right: r};
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_window(int unsigned w);
      drain();
      csr_write_enable <= 1;
      csr_write_data   <= WIN_W'(w);
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(1 << $urandom_range(15));
         4: return 16'(-(1 << $urandom_range(14)));
         default: return 16'($urandom);
      endcase
   endfunction

   // Burst of random requests; back-to-back within a burst, random gaps between.
   task automatic random_run(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(12, 1);
         for (int i = 0; i < burst && n > 0; i++, n--) begin
            req_valid <= 1;
            req <= '{sample_left: rand_sample(), sample_right: rand_sample()};
            do @(posedge clock); while (!req_ready);
         end
         req_valid <= 0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
   endtask

   int unsigned windows [8] = '{1, 2, 0, 1024, 3, 2047, 17, 256};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default window of 256, extremes of both fields.
      send_request(16'h7fff, 16'h8000);
      send_request(16'h8000, 16'h7fff);
      send_request(16'h0000, 16'hffff);
      send_request(16'h0001, 16'h0000);
      // Window of 1 tracks the sample magnitude exactly.
      set_window(1);
      send_request(16'h8000, 16'h0001);
      send_request(16'h7fff, 16'hffff);
      // dB mode: zero saturates, full-scale negative gives 0 dB.
      set_window(0);
      send_request(16'h0000, 16'h8000);
      send_request(16'h7fff, 16'h0001);
      send_request(16'hffff, 16'h4000);
      send_request(16'h5555, 16'haaaa);
      // Oversized window clamps to the maximum.
      set_window(2047);
      send_request(16'h8000, 16'h8000);
      send_request(16'h1234, 16'hedcc);
      // Window of 2 wraps the ring immediately.
      set_window(2);
      for (int i = 0; i < 6; i++) send_request(16'h8000 >> i, 16'(i * 4097));

      // Long receiver hold-off while the sender keeps offering.
      long_hold = 1;
      fork
         random_run(20);
         begin
            repeat (3000) @(posedge clock);
            long_hold = 0;
         end
      join

      // Random phases across window settings, draining before each write.
      foreach (windows[k]) begin
         set_window(windows[k]);
         random_run(windows[k] == 1024 ? 300 : 195);
      end
      drain();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

`default_nettype wire
